// ===== rtl/nsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command type and helpers for the NMEA sentence rewriter.
package nsr_pkg;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  // 'A' minus ten, so that a nibble of ten or more maps onto 'A' to 'F'.
  localparam logic [7:0] CH_HEX_BASE = 8'h37;

  localparam logic [4:0] FIELD_MAX   = 5'd31;
  localparam logic [4:0] FIELD_TIME  = 5'd1;
  localparam logic [4:0] FIELD_SATS  = 5'd7;
  localparam logic [4:0] FIELD_LAT_GGA = 5'd2;
  localparam logic [4:0] FIELD_LAT_RMC = 5'd3;
  localparam logic [4:0] FIELD_LON_GGA = 5'd4;
  localparam logic [4:0] FIELD_LON_RMC = 5'd5;

  // Worst case number of commands one input byte can cause.
  localparam int unsigned MAX_OPS = 8;
  localparam int unsigned OPS_IW  = 3;
  localparam int unsigned OPS_CW  = 4;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PW    = 2;
  localparam int unsigned CMD_CW    = 3;

  typedef enum logic [1:0] {
    OP_EMIT   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_FINISH = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       xor_en;
    logic       last;
  } cmd_t;

  function automatic cmd_t mk_cmd(input op_kind_e kind, input logic [7:0] data,
                                  input logic xor_en, input logic last);
    cmd_t c;
    c.kind   = kind;
    c.data   = data;
    c.xor_en = xor_en;
    c.last   = last;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? CH_ZERO : CH_HEX_BASE;
    return base + {4'b0000, nib};
  endfunction

endpackage

// ===== rtl/nsr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts sentence bytes, tracks fields and turns each byte into commands.
module nsr_front
  import nsr_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       sentence_kind_i,
  input  logic       in_last_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_full_i
);

  localparam int unsigned HCW = $clog2(HOLD_DEPTH);
  localparam logic [HCW-1:0] HOLD_LIM = HCW'(HOLD_DEPTH - 1);

  logic [4:0]     fi_q, fi_d;
  logic           kind_q, kind_d;
  logic           pass_q, pass_d;
  logic           star_q, star_d;
  logic [8:0]     dly_q, dly_d;
  logic [4:0]     flen_q, flen_d;
  logic           latne_q, latne_d;
  logic           pad_q, pad_d;
  logic [HCW-1:0] hc_q, hc_d;

  cmd_t              ops_q  [MAX_OPS];
  cmd_t              list_d [MAX_OPS];
  logic [OPS_CW-1:0] n;
  logic [OPS_CW-1:0] cnt_q;
  logic [OPS_CW-1:0] idx_q;
  logic              busy_q;

  logic       accept;
  logic       sep;
  logic       star_hit;
  logic [4:0] lat_f;
  logic [4:0] lon_f;
  logic       sat_cur;
  logic       sat_nxt;
  logic       more;

  assign accept  = in_valid_i && !busy_q;
  assign sep     = (in_byte_i == CH_COMMA) || (in_byte_i == CH_STAR);
  assign lat_f   = kind_q ? FIELD_LAT_RMC : FIELD_LAT_GGA;
  assign lon_f   = kind_q ? FIELD_LON_RMC : FIELD_LON_GGA;
  // RMC carries no satellite count, so only GGA ever matches.
  assign sat_cur = !kind_q && (fi_q == FIELD_SATS);
  assign sat_nxt = !kind_q && (fi_d == FIELD_SATS);

  always_comb begin
    fi_d     = fi_q;
    kind_d   = kind_q;
    pass_d   = pass_q;
    star_d   = star_q;
    dly_d    = dly_q;
    flen_d   = flen_q;
    latne_d  = latne_q;
    pad_d    = pad_q;
    hc_d     = hc_q;
    n        = '0;
    list_d   = '{default: '0};
    star_hit = 1'b0;

    if (star_q || pass_q) begin
      if (!star_q) begin
        list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b0, in_last_i);
        n = n + 1'b1;
      end
    end else if (fi_q == '0) begin
      if (flen_q == '0) kind_d = sentence_kind_i;
      if (in_byte_i == CH_STAR) begin
        pass_d = 1'b1;
        list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b0, in_last_i);
        n = n + 1'b1;
      end else begin
        list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, in_last_i);
        n = n + 1'b1;
        if (in_byte_i == CH_COMMA) fi_d = FIELD_TIME;
        else if (flen_q != FIELD_MAX) flen_d = flen_q + 5'd1;
      end
    end else if ((fi_q == FIELD_TIME) && (flen_q == '0) && sep) begin
      // An empty timestamp leaves the whole sentence untouched.
      pass_d = 1'b1;
      list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b0, in_last_i);
      n = n + 1'b1;
    end else begin
      if (sep) begin
        // Close the current field.
        if (fi_q == FIELD_TIME) dly_d = '0;
        if (sat_cur && dly_d[8]) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_ZERO, 1'b1, 1'b0);
          n = n + 1'b1;
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, dly_d[7:0], 1'b1, 1'b0);
          n = n + 1'b1;
          dly_d = '0;
        end
        if ((fi_q == lon_f) && pad_d) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_ZERO, 1'b1, 1'b0);
          n = n + 1'b1;
          pad_d = 1'b0;
        end
        if ((fi_q == lon_f) && (hc_d != '0)) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
          n = n + 1'b1;
          hc_d = '0;
        end

        if (in_byte_i == CH_STAR) begin
          if (hc_d != '0) begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
            n = n + 1'b1;
            hc_d = '0;
          end
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_STAR, 1'b0, 1'b0);
          n = n + 1'b1;
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FINISH, '0, 1'b0, 1'b1);
          n = n + 1'b1;
          star_d   = 1'b1;
          star_hit = 1'b1;
        end else begin
          if (hc_d != '0) begin
            if (hc_d < HOLD_LIM) begin
              list_d[n[OPS_IW-1:0]] = mk_cmd(OP_PUSH, CH_COMMA, 1'b1, 1'b0);
              n = n + 1'b1;
              hc_d = hc_d + 1'b1;
            end else begin
              list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
              n = n + 1'b1;
              list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_COMMA, 1'b1, 1'b0);
              n = n + 1'b1;
              hc_d = '0;
            end
          end else if ((fi_q == lat_f) && latne_q) begin
            // Latitude is done; hold everything until longitude shows up.
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_PUSH, CH_COMMA, 1'b1, 1'b0);
            n = n + 1'b1;
            hc_d = HCW'(1);
          end else begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_COMMA, 1'b1, 1'b0);
            n = n + 1'b1;
          end
          if (fi_q != FIELD_MAX) fi_d = fi_q + 5'd1;
          flen_d = '0;
        end
      end else begin
        if (flen_q != FIELD_MAX) flen_d = flen_q + 5'd1;
        if (fi_q == FIELD_TIME) begin
          // Each timestamp byte waits one byte, so the last one is dropped.
          if (dly_q[8]) begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, dly_q[7:0], 1'b1, 1'b0);
            n = n + 1'b1;
          end
          dly_d = {1'b1, in_byte_i};
        end else if (fi_q == lat_f) begin
          latne_d = 1'b1;
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, 1'b0);
          n = n + 1'b1;
        end else if (hc_q != '0) begin
          if (fi_q == lon_f) begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_ZERO, 1'b1, 1'b0);
            n = n + 1'b1;
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
            n = n + 1'b1;
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, 1'b0);
            n = n + 1'b1;
            hc_d  = '0;
            pad_d = 1'b1;
          end else if (hc_q < HOLD_LIM) begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_PUSH, in_byte_i, 1'b1, 1'b0);
            n = n + 1'b1;
            hc_d = hc_q + 1'b1;
          end else begin
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
            n = n + 1'b1;
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, 1'b0);
            n = n + 1'b1;
            hc_d = '0;
          end
        end else if (sat_cur) begin
          if (flen_d == 5'd1) begin
            dly_d = {1'b1, in_byte_i};
          end else begin
            if (dly_q[8]) begin
              list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, dly_q[7:0], 1'b1, 1'b0);
              n = n + 1'b1;
            end
            dly_d = '0;
            list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, 1'b0);
            n = n + 1'b1;
          end
        end else begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, in_byte_i, 1'b1, 1'b0);
          n = n + 1'b1;
        end
      end

      if (in_last_i && !star_hit) begin
        // Sentence ends without a star: close the open field and append the checksum.
        if (fi_d == FIELD_TIME) dly_d = '0;
        if (sat_nxt && dly_d[8]) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_ZERO, 1'b1, 1'b0);
          n = n + 1'b1;
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, dly_d[7:0], 1'b1, 1'b0);
          n = n + 1'b1;
          dly_d = '0;
        end
        if ((fi_d == lon_f) && pad_d) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_EMIT, CH_ZERO, 1'b1, 1'b0);
          n = n + 1'b1;
          pad_d = 1'b0;
        end
        if (hc_d != '0) begin
          list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FLUSH, '0, 1'b1, 1'b0);
          n = n + 1'b1;
          hc_d = '0;
        end
        list_d[n[OPS_IW-1:0]] = mk_cmd(OP_FINISH, '0, 1'b0, 1'b1);
        n = n + 1'b1;
      end
    end

    if (in_last_i) begin
      fi_d    = '0;
      kind_d  = 1'b0;
      pass_d  = 1'b0;
      star_d  = 1'b0;
      dly_d   = '0;
      flen_d  = '0;
      latne_d = 1'b0;
      pad_d   = 1'b0;
      hc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q    <= '0;
      kind_q  <= 1'b0;
      pass_q  <= 1'b0;
      star_q  <= 1'b0;
      dly_q   <= '0;
      flen_q  <= '0;
      latne_q <= 1'b0;
      pad_q   <= 1'b0;
      hc_q    <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
    end else if (accept) begin
      fi_q    <= fi_d;
      kind_q  <= kind_d;
      pass_q  <= pass_d;
      star_q  <= star_d;
      dly_q   <= dly_d;
      flen_q  <= flen_d;
      latne_q <= latne_d;
      pad_q   <= pad_d;
      hc_q    <= hc_d;
      cnt_q   <= n;
      idx_q   <= '0;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      if (!more) begin
        busy_q <= 1'b0;
      end else if (!cmd_full_i) begin
        idx_q <= idx_q + 1'b1;
        if ((idx_q + 1'b1) == cnt_q) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ops_q <= list_d;
  end

  assign more        = (idx_q != cnt_q);
  assign cmd_valid_o = busy_q && more;
  assign cmd_o       = ops_q[idx_q[OPS_IW-1:0]];
  assign in_stall_o  = busy_q;

endmodule

// ===== rtl/nsr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module nsr_cmd_fifo
  import nsr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_PW-1:0] wr_q;
  logic [CMD_PW-1:0] rd_q;
  logic [CMD_CW-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CMD_CW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== rtl/nsr_back.sv =====
`timescale 1ns / 1ps
// Back end: runs commands, keeps the held bytes and the checksum, drives the output register.
module nsr_back
  import nsr_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int unsigned HCW = $clog2(HOLD_DEPTH);

  logic [7:0]     hold_q [HOLD_DEPTH];
  logic [HCW-1:0] hwr_q;
  logic [HCW-1:0] hrd_q;
  logic           fin_q;
  logic [7:0]     xor_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  logic       can_emit;
  logic       pop;
  logic       emit;
  logic [7:0] e_byte;
  logic       e_xor;
  logic       e_last;
  logic       hold_we;
  logic       flush_step;
  logic       flush_done;
  logic [7:0] hold_rd;

  assign can_emit = !out_valid_q || !out_stall_i;
  assign hold_rd  = hold_q[hrd_q];

  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    e_byte     = cmd_i.data;
    e_xor      = cmd_i.xor_en;
    e_last     = cmd_i.last;
    hold_we    = 1'b0;
    flush_step = 1'b0;
    flush_done = 1'b0;
    if (cmd_valid_i) begin
      case (cmd_i.kind)
        OP_EMIT: begin
          if (can_emit) begin
            emit = 1'b1;
            pop  = 1'b1;
          end
        end
        OP_PUSH: begin
          hold_we = 1'b1;
          pop     = 1'b1;
        end
        OP_FLUSH: begin
          if (hwr_q == '0) begin
            pop = 1'b1;
          end else if (can_emit) begin
            emit       = 1'b1;
            flush_step = 1'b1;
            e_byte     = hold_rd;
            e_xor      = 1'b1;
            e_last     = 1'b0;
            if (hrd_q == (hwr_q - 1'b1)) begin
              flush_done = 1'b1;
              pop        = 1'b1;
            end
          end
        end
        OP_FINISH: begin
          if (can_emit) begin
            emit  = 1'b1;
            e_xor = 1'b0;
            if (!fin_q) begin
              e_byte = hex_char(xor_q[7:4]);
              e_last = 1'b0;
            end else begin
              e_byte = hex_char(xor_q[3:0]);
              e_last = 1'b1;
              pop    = 1'b1;
            end
          end
        end
        default: pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwr_q       <= '0;
      hrd_q       <= '0;
      fin_q       <= 1'b0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hold_we) hwr_q <= hwr_q + 1'b1;
      if (flush_done) begin
        hwr_q <= '0;
        hrd_q <= '0;
      end else if (flush_step) begin
        hrd_q <= hrd_q + 1'b1;
      end
      if (emit && (cmd_i.kind == OP_FINISH)) fin_q <= !fin_q;
      if (emit) begin
        // The checksum restarts with every sentence that goes out.
        if (e_last) xor_q <= '0;
        else if (e_xor && (e_byte != CH_DOLLAR)) xor_q <= xor_q ^ e_byte;
      end
      if (can_emit) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_we) hold_q[hwr_q] <= cmd_i.data;
    if (emit && can_emit) begin
      out_byte_q <= e_byte;
      out_last_q <= e_last;
    end
  end

  assign cmd_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/nmea_sentence_rewriter.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA sentence rewriter: front end, command queue and back end.
//
// Input channel: one sentence byte per beat on in_byte_i, with sentence_kind_i (0 GGA,
// 1 RMC, taken from the first byte) and in_last_i on the final byte. A beat moves when
// in_valid_i is high and in_stall_o is low.
// Output channel: one rewritten byte per beat on out_byte_o, out_last_o on the final
// byte, moved when out_valid_o is high and out_stall_i is low.
// The front end takes one beat and then passes each command that the byte causes to the
// queue, one per cycle while the queue is not full; it takes no new beat until it is done.
// The back end can give one output beat per cycle while the receiver does not stall; a
// flush gives one beat per held byte and the checksum two hex digits, and the four-entry
// command queue absorbs these bursts.
// While the receiver stalls, the output beat holds and the queue fills; once it is full
// the front end stops and in_stall_o stays high.
// Reset clears the field tracking, the queue, the held-byte count and the output valid;
// the first byte after reset starts a new sentence.
module nmea_sentence_rewriter
  import nsr_pkg::*;
#(
  parameter int unsigned HOLD_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       sentence_kind_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic cmd_valid;
  cmd_t cmd_in;
  logic cmd_full;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  nsr_front #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .sentence_kind_i(sentence_kind_i),
    .in_last_i      (in_last_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full)
  );

  nsr_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_valid),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  nsr_back #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

endmodule

// ===== rtl/nsr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the NMEA sentence rewriter and their binding to the top level.
module nsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // A stalled output beat keeps its byte and its end mark.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output beat changed");

  // After the front end takes a byte, in_stall_o is high in the next cycle.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("two input beats in consecutive cycles");

  // Reset empties the output register and frees the input side.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("outputs active during reset");

endmodule

bind nmea_sentence_rewriter nsr_checker u_checker (.*);
